// ----- rtl/core/patp_pkg.sv -----
// Package for the priority aging task picker.
// Holds field widths, action and status codes, FSM state and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package patp_pkg;

   localparam int LIST_SLOTS_DEF = 16;
   localparam int PRIO_LOW_DEF   = -20;
   localparam int PRIO_HIGH_DEF  = 20;

   localparam int ID_W    = 8;
   localparam int PRIO_W  = 6;
   localparam int ENTRY_W = ID_W + 2 * PRIO_W;

   localparam logic signed [PRIO_W-1:0] AGE_FLOOR = -6'sd20;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_SET    = 2'd2,
      ACT_PICK   = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_BOUNDS  = 3'd2,
      ST_MISSING = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       start_scan;
      logic       start_shift;
      logic       append_wr;
      logic       set_wr;
      logic       pick_wr;
      logic       count_dec;
      logic       rsp_load;
      status_type status;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    full;
      logic    empty;
      logic    bounds_bad;
      logic    found;
      logic    busy;
      logic    rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/patp_req_if.sv -----
// Request channel interface: valid/ready plus one action transaction.
// Depends on patp_pkg for field widths.
`default_nettype none
interface patp_req_if;
   import patp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               action;
   logic [ID_W-1:0]          task_ident;
   logic signed [PRIO_W-1:0] prio_value;
   logic signed [PRIO_W-1:0] aged_value;

   modport source (output valid, action, task_ident, prio_value, aged_value,
                   input ready);
   modport sink   (input valid, action, task_ident, prio_value, aged_value,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/patp_rsp_if.sv -----
// Response channel interface: valid/ready plus one result transaction.
// Depends on patp_pkg for field widths.
`default_nettype none
interface patp_rsp_if;
   import patp_pkg::*;

   logic            valid;
   logic            ready;
   logic [ID_W-1:0] chosen_task;
   logic            chosen_valid;
   logic [2:0]      status_code;

   modport source (output valid, chosen_task, chosen_valid, status_code,
                   input ready);
   modport sink   (input valid, chosen_task, chosen_valid, status_code,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/patp_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module patp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/core/patp_dp.sv -----
// Datapath: ready list RAM, entry walker, match/minimum tracking, count
// and the response register. Depends on patp_pkg and patp_ram.
`default_nettype none
module patp_dp #(
   parameter int LIST_SLOTS = patp_pkg::LIST_SLOTS_DEF,
   parameter int PRIO_LOW   = patp_pkg::PRIO_LOW_DEF,
   parameter int PRIO_HIGH  = patp_pkg::PRIO_HIGH_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire patp_pkg::cmd_type                       cmd,
   output patp_pkg::sts_type                            sts,
   input  wire logic [1:0]                              req_action,
   input  wire logic [patp_pkg::ID_W-1:0]               req_task_ident,
   input  wire logic signed [patp_pkg::PRIO_W-1:0]      req_prio_value,
   input  wire logic signed [patp_pkg::PRIO_W-1:0]      req_aged_value,
   input  wire logic                                    rsp_ready,
   output logic                                         rsp_valid,
   output logic [patp_pkg::ID_W-1:0]                    rsp_chosen_task,
   output logic                                         rsp_chosen_valid,
   output logic [2:0]                                   rsp_status_code
);
   import patp_pkg::*;

   localparam int IDX_W = $clog2(LIST_SLOTS);
   localparam int CNT_W = $clog2(LIST_SLOTS + 1);
   localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(LIST_SLOTS);
   localparam logic signed [7:0] LOW_B    = 8'(PRIO_LOW);
   localparam logic signed [7:0] HIGH_B   = 8'(PRIO_HIGH);

   act_type                  act_ff, act_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic signed [PRIO_W-1:0] prio_ff, prio_in;
   logic signed [PRIO_W-1:0] aged_ff, aged_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             walk_ff, walk_in;
   logic             shift_ff, shift_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             dat_vld_ff, dat_vld_in;
   logic [IDX_W-1:0] dat_idx_ff, dat_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] pos_ff, pos_in;

   logic [IDX_W-1:0]         best_ff, best_in;
   logic [ID_W-1:0]          best_id_ff, best_id_in;
   logic signed [PRIO_W-1:0] best_base_ff, best_base_in;
   logic signed [PRIO_W-1:0] best_aged_ff, best_aged_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_task_ff, rsp_task_in;
   logic             rsp_cvalid_ff, rsp_cvalid_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic               we;
   logic [IDX_W-1:0]   waddr;
   logic [ENTRY_W-1:0] wdata;
   logic [IDX_W-1:0]   raddr;
   logic [ENTRY_W-1:0] rd_data;

   logic [ID_W-1:0]          dat_id;
   logic signed [PRIO_W-1:0] dat_base;
   logic signed [PRIO_W-1:0] dat_aged;
   logic signed [PRIO_W-1:0] aged_dec;
   logic signed [7:0]        prio_ext;
   logic                     issue;

   patp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LIST_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rd_data)
   );

   assign dat_id   = rd_data[ENTRY_W-1 -: ID_W];
   assign dat_base = rd_data[2*PRIO_W-1 -: PRIO_W];
   assign dat_aged = rd_data[PRIO_W-1:0];
   assign aged_dec = (dat_aged > AGE_FLOOR) ? dat_aged - 6'sd1 : dat_aged;
   assign prio_ext = 8'(prio_ff);
   assign issue    = walk_ff && (rd_idx_ff < count_ff);
   assign raddr    = rd_idx_ff[IDX_W-1:0];

   always_comb begin
      act_in        = act_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      aged_in       = aged_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      shift_in      = shift_ff;
      rd_idx_in     = rd_idx_ff;
      dat_vld_in    = 1'b0;
      dat_idx_in    = dat_idx_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      best_in       = best_ff;
      best_id_in    = best_id_ff;
      best_base_in  = best_base_ff;
      best_aged_in  = best_aged_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_status_in = rsp_status_ff;
      we            = 1'b0;
      waddr         = '0;
      wdata         = '0;

      if (cmd.load_req) begin
         act_in  = act_type'(req_action);
         id_in   = req_task_ident;
         prio_in = req_prio_value;
         aged_in = req_aged_value;
      end

      if (walk_ff) begin
         if (issue) begin
            rd_idx_in  = rd_idx_ff + CNT_W'(1);
            dat_vld_in = 1'b1;
            dat_idx_in = raddr;
         end else begin
            walk_in = 1'b0;
         end
      end

      if (cmd.start_scan) begin
         walk_in   = 1'b1;
         shift_in  = 1'b0;
         rd_idx_in = '0;
         found_in  = 1'b0;
      end
      if (cmd.start_shift) begin
         walk_in   = 1'b1;
         shift_in  = 1'b1;
         rd_idx_in = CNT_W'(pos_ff) + CNT_W'(1);
      end

      if (dat_vld_ff) begin
         if (shift_ff) begin
            we    = 1'b1;
            waddr = dat_idx_ff - IDX_W'(1);
            wdata = rd_data;
         end else if (act_ff == ACT_PICK) begin
            we    = 1'b1;
            waddr = dat_idx_ff;
            wdata = {dat_id, dat_base, aged_dec};
            if (dat_idx_ff == '0 || dat_aged < best_aged_ff) begin
               best_in      = dat_idx_ff;
               best_id_in   = dat_id;
               best_base_in = dat_base;
               best_aged_in = dat_aged;
            end
         end else if (!found_ff && dat_id == id_ff) begin
            found_in = 1'b1;
            pos_in   = dat_idx_ff;
         end
      end

      if (cmd.append_wr) begin
         we       = 1'b1;
         waddr    = count_ff[IDX_W-1:0];
         wdata    = {id_ff, prio_ff, aged_ff};
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.set_wr) begin
         we    = 1'b1;
         waddr = pos_ff;
         wdata = {id_ff, prio_ff, prio_ff};
      end
      if (cmd.pick_wr) begin
         we    = 1'b1;
         waddr = best_ff;
         wdata = {best_id_ff, best_base_ff, best_base_ff};
      end
      if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.status;
         rsp_cvalid_in = (cmd.status == ST_OK) && (act_ff == ACT_PICK);
         rsp_task_in   = rsp_cvalid_in ? best_id_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         walk_ff      <= 1'b0;
         dat_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         dat_vld_ff   <= dat_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      aged_ff       <= aged_in;
      shift_ff      <= shift_in;
      rd_idx_ff     <= rd_idx_in;
      dat_idx_ff    <= dat_idx_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      best_ff       <= best_in;
      best_id_ff    <= best_id_in;
      best_base_ff  <= best_base_in;
      best_aged_ff  <= best_aged_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      sts.act        = act_ff;
      sts.full       = (count_ff == FULL_CNT);
      sts.empty      = (count_ff == '0);
      sts.bounds_bad = (prio_ext < LOW_B) || (prio_ext > HIGH_B);
      sts.found      = found_ff;
      sts.busy       = walk_ff || dat_vld_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_task  = rsp_task_ff;
   assign rsp_chosen_valid = rsp_cvalid_ff;
   assign rsp_status_code  = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("ready count above list size");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append_wr |-> count_ff < FULL_CNT)
      else $error("append written into a full list");

   a_chosen_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cvalid_ff |-> rsp_status_ff == ST_OK)
      else $error("chosen task flagged with a failing status");

   a_shift_idx: assert property (@(posedge clock) disable iff (reset)
      dat_vld_ff && shift_ff |-> dat_idx_ff != '0)
      else $error("shift moved the head entry");
endmodule
`default_nettype wire

// ----- rtl/core/patp_ctrl.sv -----
// Controller FSM: sequences each transaction through the datapath walks
// and decides the status code. Depends on patp_pkg.
`default_nettype none
module patp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire patp_pkg::sts_type sts,
   output patp_pkg::cmd_type      cmd
);
   import patp_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      req_ready       = 1'b0;
      cmd.load_req    = 1'b0;
      cmd.start_scan  = 1'b0;
      cmd.start_shift = 1'b0;
      cmd.append_wr   = 1'b0;
      cmd.set_wr      = 1'b0;
      cmd.pick_wr     = 1'b0;
      cmd.count_dec   = 1'b0;
      cmd.rsp_load    = 1'b0;
      cmd.status      = status_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            state_in  = S_DONE;
            case (sts.act)
               ACT_APPEND: begin
                  if (sts.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.append_wr = 1'b1;
                  end
               end
               ACT_SET: begin
                  if (sts.bounds_bad) begin
                     status_in = ST_BOUNDS;
                  end else begin
                     cmd.start_scan = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               ACT_PICK: begin
                  if (sts.empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cmd.start_scan = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  cmd.start_scan = 1'b1;
                  state_in       = S_SCAN;
               end
            endcase
         end
         S_SCAN: begin
            if (!sts.busy) begin
               state_in = S_DONE;
               if (sts.act == ACT_PICK) begin
                  cmd.pick_wr = 1'b1;
               end else if (!sts.found) begin
                  status_in = ST_MISSING;
               end else if (sts.act == ACT_REMOVE) begin
                  cmd.start_shift = 1'b1;
                  state_in        = S_SHIFT;
               end else begin
                  cmd.set_wr = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            if (!sts.busy) begin
               cmd.count_dec = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/core/priority_aging_task_picker_top.sv -----
// Top level of the priority aging task picker.
// Depends on patp_pkg, patp_req_if, patp_rsp_if, patp_ctrl and patp_dp.
//
// Usage:
//   req_ch carries one transaction: action (append, remove, set priority,
//   pick), task_ident, prio_value and aged_value. rsp_ch returns exactly one
//   transaction per request: chosen_task, chosen_valid and status_code.
//   Both channels transfer on a clock edge with valid and ready high.
//   One request is in flight at a time; req_ch.ready is high while the
//   controller is idle. The response sits in an output register, so the
//   next request is taken while an earlier response waits on rsp_ch.
//   Append, a rejected set priority and a pick on an empty list finish
//   without an entry walk. Set priority, pick and remove walk the list
//   RAM, one entry per cycle on its single read port; a remove walks
//   again to close the gap. Reset empties the list and drops any pending
//   response. A stalled rsp_ch holds the finished response and holds off
//   the next completion.
`default_nettype none
module priority_aging_task_picker_top #(
   parameter int LIST_SLOTS = patp_pkg::LIST_SLOTS_DEF,
   parameter int PRIO_LOW   = patp_pkg::PRIO_LOW_DEF,
   parameter int PRIO_HIGH  = patp_pkg::PRIO_HIGH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   patp_req_if.sink   req_ch,
   patp_rsp_if.source rsp_ch
);
   import patp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   patp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   patp_dp #(
      .LIST_SLOTS (LIST_SLOTS),
      .PRIO_LOW   (PRIO_LOW),
      .PRIO_HIGH  (PRIO_HIGH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_ch.action),
      .req_task_ident   (req_ch.task_ident),
      .req_prio_value   (req_ch.prio_value),
      .req_aged_value   (req_ch.aged_value),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_chosen_task  (rsp_ch.chosen_task),
      .rsp_chosen_valid (rsp_ch.chosen_valid),
      .rsp_status_code  (rsp_ch.status_code)
   );
endmodule
`default_nettype wire
